[src/bsel_pkg.sv]
// Shared types, codes and constants of the backend selector.
package bsel_pkg;

  localparam int MAX_BACKENDS = 8;
  localparam int IDX_W        = 3;   // bits of a backend index
  localparam int CNT_W        = 4;   // holds 0 .. MAX_BACKENDS
  localparam int ACT_W        = 16;
  localparam int REQ_W        = 32;
  localparam int ADDR_W       = 32;
  localparam int HASH_ROUNDS  = 4;   // one round per address byte
  localparam int MOD_BITS     = 4;   // dividend bits retired per modulo step
  localparam int MOD_STEPS    = 32 / MOD_BITS;
  localparam int MOD_CNT_W    = $clog2(MOD_STEPS);

  localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
  localparam logic [8:0]  FNV_LOW    = 9'h193;  // prime is 2^24 + 0x193

  // algorithm register codes; code three behaves as address hash
  localparam logic [1:0] ALG_ROUND_ROBIN = 2'd0;
  localparam logic [1:0] ALG_LEAST_CONN  = 2'd1;
  localparam logic [1:0] ALG_ADDR_HASH   = 2'd2;

  // configuration register indexes
  localparam logic CFG_ALGORITHM = 1'b0;
  localparam logic CFG_BACKENDS  = 1'b1;

  typedef enum logic [2:0] {
    KIND_SELECT = 3'd0,
    KIND_HEALTH = 3'd1,
    KIND_OPEN   = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_ABORT  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MOD,
    ST_FIND,
    ST_EMIT,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic load;       // capture input beat, clear scan state
    logic scan_step;  // visit one backend, run a hash round while rounds remain
    logic decide;     // latch least-connections pick, seed modulo
    logic mod_step;   // retire MOD_BITS dividend bits
    logic find_clr;   // restart walk for the list position
    logic find_step;  // visit one backend looking for the position
    logic emit;       // post select result
    logic upd;        // apply update kind and post its result
  } cmd_t;

  typedef struct packed {
    logic in_sel;     // offered beat is a select
    logic scan_last;
    logic cnt_zero;   // no healthy backend in use
    logic algo_lc;
    logic mod_last;
    logic find_hit;
    logic out_busy;   // output register full and stalled
  } status_t;

endpackage

[src/bsel_ctrl.sv]
// Sequencer of the backend selector: steps scan, modulo, find and result.
module bsel_ctrl
  import bsel_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_sel ? ST_SCAN : ST_UPD;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (status_i.cnt_zero || status_i.algo_lc) state_d = ST_EMIT;
        else state_d = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) begin
          cmd_o.find_clr = 1'b1;
          state_d        = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd_o.find_step = 1'b1;
        if (status_i.find_hit) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_UPD: begin
        if (!status_i.out_busy) begin
          cmd_o.upd = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[src/bsel_datapath.sv]
// Datapath of the backend selector: backend state, hash, modulo and result register.
module bsel_datapath
  import bsel_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [3:0]    cfg_wdata_i,
  input  logic [2:0]    in_kind_i,
  input  logic [IDX_W-1:0]  in_idx_i,
  input  logic          in_health_i,
  input  logic [ADDR_W-1:0] in_addr_i,
  input  cmd_t          cmd_i,
  output status_t       status_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [IDX_W-1:0]  out_sel_o,
  output logic          out_none_o,
  output logic [ACT_W-1:0]  out_act_o,
  output logic [REQ_W-1:0]  out_req_o
);

  // configuration
  logic [1:0]       algo_q;
  logic [CNT_W-1:0] biu_q;

  // backend state
  logic             health_q [MAX_BACKENDS];
  logic [ACT_W-1:0] act_q    [MAX_BACKENDS];
  logic [REQ_W-1:0] req_q    [MAX_BACKENDS];
  logic [31:0]      rot_q;

  // captured beat
  logic [2:0]        kind_q;
  logic [IDX_W-1:0]  idx_q;
  logic              hv_q;
  logic [ADDR_W-1:0] addr_sh_q;

  // select working state
  logic [CNT_W-1:0] scan_q, cnt_q, seen_q, rem_q, rem_d;
  logic [ACT_W:0]   best_q;
  logic [IDX_W-1:0] best_idx_q, pick_q;
  logic [31:0]      hash_q, hash_x, hash_d, div_q;
  logic [MOD_CNT_W-1:0] mod_cnt_q;

  // output register
  logic              out_valid_q, out_none_q;
  logic [IDX_W-1:0]  out_sel_q;
  logic [ACT_W-1:0]  out_act_q;
  logic [REQ_W-1:0]  out_req_q;

  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] scan_idx;
  logic             scan_healthy, hash_step, find_hit;
  logic [ACT_W-1:0] act_cur, act_new;
  logic [REQ_W-1:0] req_cur, req_new;
  logic             kind_known;

  assign n_eff        = (biu_q > CNT_W'(MAX_BACKENDS)) ? CNT_W'(MAX_BACKENDS) : biu_q;
  assign scan_idx     = scan_q[IDX_W-1:0];
  assign scan_healthy = (scan_q < n_eff) && health_q[scan_idx];
  assign hash_step    = cmd_i.scan_step && (scan_q < CNT_W'(HASH_ROUNDS));
  assign find_hit     = scan_healthy && (seen_q == rem_q);

  // FNV-1a round: xor the byte, multiply by 2^24 + 0x193
  assign hash_x = hash_q ^ {24'd0, addr_sh_q[ADDR_W-1 -: 8]};
  assign hash_d = {hash_x[7:0], 24'd0} + (hash_x * {23'd0, FNV_LOW});

  // remainder by the healthy count, dividend MSB first
  always_comb begin
    logic [CNT_W-1:0] r;
    r = rem_q;
    for (int j = 0; j < MOD_BITS; j++) begin
      r = {r[CNT_W-2:0], div_q[31-j]};
      if (r >= cnt_q) r = r - cnt_q;
    end
    rem_d = r;
  end

  // update kinds: saturate active count at both ends
  always_comb begin
    act_cur    = act_q[idx_q];
    req_cur    = req_q[idx_q];
    act_new    = act_cur;
    req_new    = req_cur;
    kind_known = 1'b1;
    unique case (kind_q)
      KIND_HEALTH: ;
      KIND_OPEN: begin
        if (act_cur != '1) act_new = act_cur + 1'b1;
      end
      KIND_DONE: begin
        req_new = req_cur + 1'b1;
        if (act_cur != '0) act_new = act_cur - 1'b1;
      end
      KIND_ABORT: begin
        if (act_cur != '0) act_new = act_cur - 1'b1;
      end
      default: kind_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      algo_q <= ALG_ROUND_ROBIN;
      biu_q  <= CNT_W'(3);
      rot_q  <= '0;
      for (int i = 0; i < MAX_BACKENDS; i++) begin
        health_q[i] <= 1'b1;
        act_q[i]    <= '0;
        req_q[i]    <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ALGORITHM) algo_q <= cfg_wdata_i[1:0];
        else biu_q <= cfg_wdata_i;
      end
      if (cmd_i.upd) begin
        if (kind_q == KIND_HEALTH) health_q[idx_q] <= hv_q;
        act_q[idx_q] <= act_new;
        req_q[idx_q] <= req_new;
      end
      if (cmd_i.emit && (cnt_q != '0) && (algo_q == ALG_ROUND_ROBIN)) begin
        rot_q <= rot_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= in_kind_i;
      idx_q     <= in_idx_i;
      hv_q      <= in_health_i;
      addr_sh_q <= in_addr_i;
      hash_q    <= FNV_OFFSET;
      scan_q    <= '0;
      cnt_q     <= '0;
      best_q    <= {1'b1, {ACT_W{1'b0}}};
      best_idx_q <= '0;
    end
    if (cmd_i.scan_step) begin
      scan_q <= scan_q + 1'b1;
      if (scan_healthy) begin
        cnt_q <= cnt_q + 1'b1;
        if ({1'b0, act_q[scan_idx]} < best_q) begin
          best_q     <= {1'b0, act_q[scan_idx]};
          best_idx_q <= scan_idx;
        end
      end
    end
    if (hash_step) begin
      hash_q    <= hash_d;
      addr_sh_q <= {addr_sh_q[ADDR_W-9:0], 8'd0};
    end
    if (cmd_i.decide) begin
      pick_q    <= best_idx_q;
      div_q     <= (algo_q == ALG_ROUND_ROBIN) ? rot_q : hash_q;
      rem_q     <= '0;
      mod_cnt_q <= '0;
    end
    if (cmd_i.mod_step) begin
      rem_q     <= rem_d;
      div_q     <= {div_q[31-MOD_BITS:0], {MOD_BITS{1'b0}}};
      mod_cnt_q <= mod_cnt_q + 1'b1;
    end
    if (cmd_i.find_clr) begin
      scan_q <= '0;
      seen_q <= '0;
    end
    if (cmd_i.find_step) begin
      scan_q <= scan_q + 1'b1;
      if (scan_healthy) seen_q <= seen_q + 1'b1;
      if (find_hit) pick_q <= scan_idx;
    end
  end

  // result register: hold until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.upd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cnt_q == '0) begin
        out_sel_q  <= '0;
        out_none_q <= 1'b1;
        out_act_q  <= '0;
        out_req_q  <= '0;
      end else begin
        out_sel_q  <= pick_q;
        out_none_q <= 1'b0;
        out_act_q  <= act_q[pick_q];
        out_req_q  <= req_q[pick_q];
      end
    end else if (cmd_i.upd) begin
      out_sel_q  <= '0;
      out_none_q <= 1'b0;
      out_act_q  <= kind_known ? act_new : '0;
      out_req_q  <= kind_known ? req_new : '0;
    end
  end

  assign status_o.in_sel    = (in_kind_i == KIND_SELECT);
  assign status_o.scan_last = (scan_q == CNT_W'(MAX_BACKENDS - 1));
  assign status_o.cnt_zero  = (cnt_q == '0);
  assign status_o.algo_lc   = (algo_q == ALG_LEAST_CONN);
  assign status_o.mod_last  = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
  assign status_o.find_hit  = find_hit;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_sel_o   = out_sel_q;
  assign out_none_o  = out_none_q;
  assign out_act_o   = out_act_q;
  assign out_req_o   = out_req_q;

endmodule

[src/backend_selector.sv]
// Top level of the backend selector: stream ports, sequencer and datapath.
//
// Usage: each input beat on the s_axis channel carries one command, its kind
// in tuser. A select (kind 0) picks a backend among the healthy ones of the
// first backends_in_use by round robin, least connections or address hash.
// Kinds 1 to 4 set health, open a connection, finish a request or abort one.
// Every input beat yields exactly one output beat on m_axis.
// Update kinds apply their change and post their result. A select walks
// all eight backends (the four hash rounds ride along), then decides; least
// connections, or a select with no healthy backend, then posts its result.
// Round robin and hash run an 8-step remainder unit, 4 dividend bits a step,
// then walk the backends again to the chosen list position and post it.
// One command is in flight at a time; the next beat is taken only when idle.
// The output register decouples the sides: a new beat is taken while the last
// result still waits; if the receiver stalls, the next result holds in its
// final state until the register frees.
// Reset: all backends healthy with zero counts, rotation counter zero,
// algorithm round robin, three backends in use. Write configuration only idle.
module backend_selector
  import bsel_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_wdata_i,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // backend[2:0], health[3], client_ip[35:4]
  input  logic [2:0]  s_axis_tuser,   // kind[2:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // selected_backend[2:0], active_count[18:3],
                                      // request_total[50:19]
  output logic        m_axis_tuser    // none_healthy
);

  cmd_t    cmd;
  status_t status;

  logic [IDX_W-1:0] out_sel;
  logic             out_none;
  logic [ACT_W-1:0] out_act;
  logic [REQ_W-1:0] out_req;

  bsel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsel_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_kind_i   (s_axis_tuser),
    .in_idx_i    (s_axis_tdata[2:0]),
    .in_health_i (s_axis_tdata[3]),
    .in_addr_i   (s_axis_tdata[35:4]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_sel_o   (out_sel),
    .out_none_o  (out_none),
    .out_act_o   (out_act),
    .out_req_o   (out_req)
  );

  // pack the result beat, pad to whole bytes
  assign m_axis_tdata = {5'd0, out_req, out_act, out_sel};
  assign m_axis_tuser = out_none;

endmodule

[src/bsel_checker.sv]
// Port-level checks of the backend selector, bound to the top level.
module bsel_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // one command in flight: busy right after taking a beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in flight");

  // posting a result returns the block to idle
  a_post_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result posted but block not idle");

  // no healthy backend reports all-zero fields
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 56'd0)
    else $error("none-healthy result carries nonzero fields");

endmodule

bind backend_selector bsel_checker u_bsel_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
